@@ hw/rtl/tksd_pkg.sv @@
// Shared types, constants and lookup functions for the terminal key sequence decoder.
// Used by the channel interfaces, the parser, the output buffer and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tksd_pkg;

  localparam int NUMBER_WIDTH = 16;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic       mod_shift;
    logic       mod_alt;
    logic       mod_ctrl;
    logic [7:0] key_code;
    logic [7:0] mouse_column;
    logic [7:0] mouse_row;
    logic [2:0] mouse_button;
  } out_item_t;

  typedef struct packed {
    logic main_valid;
    logic skid_full;
  } buf_status_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } key_hit_t;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_IDLE = 1'b1;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_CHAR  = 2'd1;
  localparam logic [1:0] EV_KEY   = 2'd2;
  localparam logic [1:0] EV_MOUSE = 2'd3;

  localparam logic [7:0] KEY_TAB   = 8'd0;
  localparam logic [7:0] KEY_ENTER = 8'd1;
  localparam logic [7:0] KEY_ESC   = 8'd2;
  localparam logic [7:0] KEY_BKSP  = 8'd3;
  localparam logic [7:0] KEY_UP    = 8'd4;
  localparam logic [7:0] KEY_DOWN  = 8'd5;
  localparam logic [7:0] KEY_RIGHT = 8'd6;
  localparam logic [7:0] KEY_LEFT  = 8'd7;
  localparam logic [7:0] KEY_HOME  = 8'd8;
  localparam logic [7:0] KEY_END   = 8'd9;
  localparam logic [7:0] KEY_INS   = 8'd10;
  localparam logic [7:0] KEY_DEL   = 8'd11;
  localparam logic [7:0] KEY_PGUP  = 8'd12;
  localparam logic [7:0] KEY_PGDN  = 8'd13;
  localparam logic [7:0] KEY_F1    = 8'd14;

  // modifier bits: shift, alt, ctrl from LSB
  localparam logic [2:0] MOD_NONE  = 3'b000;
  localparam logic [2:0] MOD_SHIFT = 3'b001;
  localparam logic [2:0] MOD_ALT   = 3'b010;
  localparam logic [2:0] MOD_CTRL  = 3'b100;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_CTRL_A   = 8'h01;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_CTRL_Z   = 8'h1A;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_US       = 8'h1F;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CH_FF       = 8'hFF;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_ONE      = 8'h31;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_UP_A     = 8'h41;
  localparam logic [7:0] CH_UP_B     = 8'h42;
  localparam logic [7:0] CH_UP_C     = 8'h43;
  localparam logic [7:0] CH_UP_D     = 8'h44;
  localparam logic [7:0] CH_UP_F     = 8'h46;
  localparam logic [7:0] CH_UP_H     = 8'h48;
  localparam logic [7:0] CH_UP_M     = 8'h4D;
  localparam logic [7:0] CH_UP_O     = 8'h4F;
  localparam logic [7:0] CH_UP_P     = 8'h50;
  localparam logic [7:0] CH_UP_Q     = 8'h51;
  localparam logic [7:0] CH_UP_R     = 8'h52;
  localparam logic [7:0] CH_UP_S     = 8'h53;
  localparam logic [7:0] CH_UP_Z     = 8'h5A;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_LO_A     = 8'h61;
  localparam logic [7:0] CH_LO_Z     = 8'h7A;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CTRL_OFFSET = 8'h40;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] MOUSE_BIAS  = 8'd33;

  function automatic out_item_t make_event(input logic [1:0] kind, input logic [2:0] mods,
                                           input logic [7:0] code);
    out_item_t ev;
    ev.event_kind   = kind;
    ev.mod_shift    = mods[0];
    ev.mod_alt      = mods[1];
    ev.mod_ctrl     = mods[2];
    ev.key_code     = code;
    ev.mouse_column = 8'd0;
    ev.mouse_row    = 8'd0;
    ev.mouse_button = 3'd0;
    return ev;
  endfunction

  // key number of a CSI "n ~" sequence, for n below 32
  function automatic key_hit_t tilde_lookup(input logic [4:0] n);
    key_hit_t r;
    r.hit  = 1'b1;
    r.code = KEY_HOME;
    unique case (n)
      5'd1, 5'd7: r.code = KEY_HOME;
      5'd2, 5'd8: r.code = KEY_INS;
      5'd3:       r.code = KEY_DEL;
      5'd4:       r.code = KEY_END;
      5'd5:       r.code = KEY_PGUP;
      5'd6:       r.code = KEY_PGDN;
      5'd11, 5'd12, 5'd13, 5'd14, 5'd15:
        r.code = KEY_F1 + {3'd0, n} - 8'd11;
      5'd17, 5'd18, 5'd19, 5'd20, 5'd21:
        r.code = KEY_F1 + {3'd0, n} - 8'd12;
      5'd23, 5'd24:
        r.code = KEY_F1 + {3'd0, n} - 8'd13;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // final byte of an SS3 sequence
  function automatic key_hit_t ss3_lookup(input logic [7:0] ch);
    key_hit_t r;
    r.hit  = 1'b1;
    r.code = KEY_END;
    unique case (ch)
      CH_UP_F: r.code = KEY_END;
      CH_UP_H: r.code = KEY_HOME;
      CH_UP_P, CH_UP_Q, CH_UP_R, CH_UP_S: r.code = KEY_F1 + (ch - CH_UP_P);
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tksd_in_if.sv @@
// Input channel of the decoder: valid/ready handshake carrying one received byte or idle.
// Depends on tksd_pkg for the payload type.
`timescale 1ns / 1ps
`default_nettype none

interface tksd_in_if;
  logic               valid;
  logic               ready;
  tksd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tksd_out_if.sv @@
// Output channel of the decoder: valid/ready handshake carrying one key or mouse event.
// Depends on tksd_pkg for the payload type.
`timescale 1ns / 1ps
`default_nettype none

interface tksd_out_if;
  logic                valid;
  logic                ready;
  tksd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/terminal_key_sequence_decoder_top.sv @@
// Terminal key sequence decoder: input register, sequence parser and output buffer.
// Depends on tksd_pkg, tksd_in_if, tksd_out_if, tksd_parser and tksd_out_buf.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// in_i carries one item per handshake: a received terminal byte (cmd = 0) or an
// idle marker (cmd = 1) that tells the decoder no further byte is pending, so an
// open sequence such as a lone ESC is closed. out_o carries at most one event per
// item: kind, Shift/Alt/Ctrl, key code and the mouse column, row and button.
// Items that only advance a sequence (ESC, CSI parameters, mouse report bytes)
// give no event.
// An accepted item is held in the input register and decoded by the parser, and
// its event is registered in the output buffer before it is shown on out_o.
// Throughput: one item per cycle while the skid entry is free; the parser handles
// a whole byte combinationally between the input register and the output register.
// Stall: the output holds a result register plus one skid entry. While the
// receiver stalls, both fill, then the item in the input register waits and
// in_i.ready drops until the receiver takes an event.
// Reset (rst_ni low, asynchronous): the parser returns to the ground state with
// cleared parameters, and all pending items and events are dropped.
module terminal_key_sequence_decoder_top #(
  parameter int NUMBER_WIDTH = tksd_pkg::NUMBER_WIDTH
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tksd_in_if.sink     in_i,
  tksd_out_if.source  out_o
);

  tksd_pkg::in_item_t    in_q;
  logic                  in_valid_q, in_valid_d;
  logic                  in_take;
  logic                  advance;
  logic                  ev_valid;
  tksd_pkg::out_item_t   ev;
  tksd_pkg::buf_status_t buf_status;

  // move the held item into the parser when the buffer has room
  assign advance  = in_valid_q && !buf_status.skid_full;
  assign in_i.ready = !in_valid_q || advance;
  assign in_take  = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_q <= in_i.data;
  end

  tksd_parser #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (in_q),
    .ev_valid_o (ev_valid),
    .ev_o       (ev)
  );

  tksd_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (ev_valid),
    .ev_i     (ev),
    .status_o (buf_status),
    .out_o    (out_o)
  );

`ifndef SYNTH
  // an event never arrives when both buffer entries are taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid |-> !buf_status.skid_full)
    else $error("event pushed into a full output buffer");

  // the skid entry is only used behind a valid result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_status.skid_full |-> out_o.valid)
    else $error("skid entry occupied with empty result register");

  // the skid entry only fills while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(buf_status.skid_full) |-> $past(out_o.valid && !out_o.ready))
    else $error("skid entry filled without a stalled receiver");

  // a parser step needs a held item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid |-> in_valid_q)
    else $error("event produced without an input item");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/tksd_parser.sv @@
// Escape sequence parser: holds the sequence state and decodes one item per step.
// Depends on tksd_pkg for item types, byte constants and key lookups.
`timescale 1ns / 1ps
`default_nettype none

module tksd_parser #(
  parameter int NUMBER_WIDTH = tksd_pkg::NUMBER_WIDTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire tksd_pkg::in_item_t  item_i,
  output logic                     ev_valid_o,
  output tksd_pkg::out_item_t      ev_o
);

  typedef enum logic [12:0] {
    ST_GROUND    = 13'h0001,
    ST_ESC       = 13'h0002,
    ST_CSI       = 13'h0004,
    ST_CSI_NUM1  = 13'h0008,
    ST_CSI_SEMI  = 13'h0010,
    ST_CSI_NUM2  = 13'h0020,
    ST_MOUSE1    = 13'h0040,
    ST_MOUSE2    = 13'h0080,
    ST_MOUSE3    = 13'h0100,
    ST_SS3       = 13'h0200,
    ST_SS3_ONE   = 13'h0400,
    ST_SS3_SEMI  = 13'h0800,
    ST_SS3_FINAL = 13'h1000
  } parse_state_e;

  parse_state_e             state_q, state_d;
  logic [NUMBER_WIDTH-1:0]  first_q, first_d;
  logic [NUMBER_WIDTH-1:0]  second_q, second_d;
  logic                     have1_q, have1_d;
  logic                     have2_q, have2_d;
  logic [7:0]               flags_q, flags_d;
  logic [7:0]               col_q, col_d;
  logic [2:0]               ss3_mods_q, ss3_mods_d;

  logic [7:0]               ch;
  logic                     digit;
  logic [NUMBER_WIDTH-1:0]  digit_val;
  tksd_pkg::key_hit_t       tilde_hit;
  tksd_pkg::key_hit_t       ss3_hit;
  logic                     csi_bad;
  logic [2:0]               csi_mods;
  logic [7:0]               csi_code;
  tksd_pkg::out_item_t      csi_ev;
  tksd_pkg::out_item_t      none_ev;
  tksd_pkg::out_item_t      mouse_ev;
  logic                     emit;
  tksd_pkg::out_item_t      ev;

  assign ch        = item_i.rx_byte;
  assign digit     = (ch >= tksd_pkg::CH_ZERO) && (ch <= tksd_pkg::CH_NINE);
  assign digit_val = NUMBER_WIDTH'(ch[3:0]);
  assign tilde_hit = tksd_pkg::tilde_lookup(first_q[4:0]);
  assign ss3_hit   = tksd_pkg::ss3_lookup(ch);
  assign none_ev   = tksd_pkg::make_event(tksd_pkg::EV_NONE, tksd_pkg::MOD_NONE, 8'd0);

  // CSI final byte: modifiers come from the last parameter given; a ~ final takes them only from the second
  always_comb begin
    csi_bad  = 1'b0;
    csi_mods = tksd_pkg::MOD_NONE;
    csi_code = tksd_pkg::KEY_TAB;
    if (ch == tksd_pkg::CH_TILDE) begin
      if (!have1_q) csi_bad = 1'b1;
      if (have2_q) begin
        if (second_q == '0) csi_bad = 1'b1;
        csi_mods = second_q[2:0] - 3'd1;
      end
      if (!tilde_hit.hit || (first_q[NUMBER_WIDTH-1:5] != '0)) csi_bad = 1'b1;
      csi_code = tilde_hit.code;
    end else begin
      if (have1_q) begin
        if (have2_q) begin
          if ((first_q != NUMBER_WIDTH'(1)) || (second_q == '0)) csi_bad = 1'b1;
          csi_mods = second_q[2:0] - 3'd1;
        end else begin
          if (first_q == '0) csi_bad = 1'b1;
          csi_mods = first_q[2:0] - 3'd1;
        end
      end
      unique case (ch)
        tksd_pkg::CH_UP_A: csi_code = tksd_pkg::KEY_UP;
        tksd_pkg::CH_UP_B: csi_code = tksd_pkg::KEY_DOWN;
        tksd_pkg::CH_UP_C: csi_code = tksd_pkg::KEY_RIGHT;
        tksd_pkg::CH_UP_D: csi_code = tksd_pkg::KEY_LEFT;
        tksd_pkg::CH_UP_F: csi_code = tksd_pkg::KEY_END;
        tksd_pkg::CH_UP_H: csi_code = tksd_pkg::KEY_HOME;
        tksd_pkg::CH_UP_Z: begin
          csi_code = tksd_pkg::KEY_TAB;
          csi_mods = tksd_pkg::MOD_SHIFT;
        end
        default: csi_bad = 1'b1;
      endcase
    end
    csi_ev = csi_bad ? none_ev : tksd_pkg::make_event(tksd_pkg::EV_KEY, csi_mods, csi_code);
  end

  // X10 report: flags byte carries button and modifiers
  always_comb begin
    mouse_ev = tksd_pkg::make_event(tksd_pkg::EV_MOUSE, flags_q[4:2], 8'd0);
    mouse_ev.mouse_column = col_q - tksd_pkg::MOUSE_BIAS;
    mouse_ev.mouse_row    = ch - tksd_pkg::MOUSE_BIAS;
    if (flags_q[6:5] == 2'b11) begin
      mouse_ev.mouse_button = flags_q[0] ? 3'd5 : 3'd4;
    end else if (flags_q[1:0] == 2'b11) begin
      mouse_ev.mouse_button = 3'd0;
    end else begin
      mouse_ev.mouse_button = {1'b0, flags_q[1:0]} + 3'd1;
    end
  end

  always_comb begin
    state_d    = state_q;
    first_d    = first_q;
    second_d   = second_q;
    have1_d    = have1_q;
    have2_d    = have2_q;
    flags_d    = flags_q;
    col_d      = col_q;
    ss3_mods_d = ss3_mods_q;
    emit       = 1'b0;
    ev         = none_ev;

    if (item_i.cmd == tksd_pkg::CMD_IDLE) begin
      // nothing more pending: close any open sequence
      emit = (state_q != ST_GROUND);
      unique case (state_q)
        ST_ESC: ev = tksd_pkg::make_event(tksd_pkg::EV_KEY, tksd_pkg::MOD_NONE,
                                          tksd_pkg::KEY_ESC);
        ST_CSI: ev = tksd_pkg::make_event(tksd_pkg::EV_CHAR, tksd_pkg::MOD_ALT,
                                          tksd_pkg::CH_LBRACKET);
        ST_SS3: ev = tksd_pkg::make_event(tksd_pkg::EV_CHAR, tksd_pkg::MOD_ALT,
                                          tksd_pkg::CH_UP_O);
        default: ev = none_ev;
      endcase
    end else begin
      unique case (state_q)
        ST_GROUND: begin
          emit = 1'b1;
          priority if (ch == tksd_pkg::CH_TAB) begin
            ev = tksd_pkg::make_event(tksd_pkg::EV_KEY, tksd_pkg::MOD_NONE,
                                      tksd_pkg::KEY_TAB);
          end else if (ch == tksd_pkg::CH_LF) begin
            ev = tksd_pkg::make_event(tksd_pkg::EV_KEY, tksd_pkg::MOD_CTRL,
                                      tksd_pkg::KEY_ENTER);
          end else if (ch == tksd_pkg::CH_CR) begin
            ev = tksd_pkg::make_event(tksd_pkg::EV_KEY, tksd_pkg::MOD_NONE,
                                      tksd_pkg::KEY_ENTER);
          end else if ((ch >= tksd_pkg::CH_CTRL_A) && (ch <= tksd_pkg::CH_CTRL_Z)) begin
            ev = tksd_pkg::make_event(tksd_pkg::EV_CHAR, tksd_pkg::MOD_CTRL,
                                      ch + tksd_pkg::CTRL_OFFSET);
          end else if (ch == tksd_pkg::CH_ESC) begin
            emit    = 1'b0;
            state_d = ST_ESC;
          end else if (ch == tksd_pkg::CH_US) begin
            ev = tksd_pkg::make_event(tksd_pkg::EV_CHAR,
                                      tksd_pkg::MOD_CTRL | tksd_pkg::MOD_ALT,
                                      tksd_pkg::CH_MINUS);
          end else if (ch == tksd_pkg::CH_DEL) begin
            ev = tksd_pkg::make_event(tksd_pkg::EV_KEY, tksd_pkg::MOD_NONE,
                                      tksd_pkg::KEY_BKSP);
          end else if ((ch == tksd_pkg::CH_NUL) || (ch == tksd_pkg::CH_FF)) begin
            ev = none_ev;
          end else begin
            ev = tksd_pkg::make_event(tksd_pkg::EV_CHAR, tksd_pkg::MOD_NONE, ch);
          end
        end

        ST_ESC: begin
          emit = 1'b1;
          priority if (ch == tksd_pkg::CH_ESC) begin
            ev = tksd_pkg::make_event(tksd_pkg::EV_KEY, tksd_pkg::MOD_NONE,
                                      tksd_pkg::KEY_ESC);
          end else if (ch == tksd_pkg::CH_LF) begin
            ev = tksd_pkg::make_event(tksd_pkg::EV_KEY, tksd_pkg::MOD_ALT,
                                      tksd_pkg::KEY_ENTER);
          end else if ((ch >= tksd_pkg::CH_CTRL_A) && (ch <= tksd_pkg::CH_CTRL_Z)) begin
            ev = tksd_pkg::make_event(tksd_pkg::EV_CHAR,
                                      tksd_pkg::MOD_CTRL | tksd_pkg::MOD_ALT,
                                      ch + tksd_pkg::CTRL_OFFSET);
          end else if (ch == tksd_pkg::CH_US) begin
            ev = tksd_pkg::make_event(tksd_pkg::EV_CHAR,
                                      tksd_pkg::MOD_CTRL | tksd_pkg::MOD_ALT |
                                      tksd_pkg::MOD_SHIFT, tksd_pkg::CH_MINUS);
          end else if (ch == tksd_pkg::CH_LBRACKET) begin
            emit     = 1'b0;
            first_d  = '0;
            second_d = '0;
            have1_d  = 1'b0;
            have2_d  = 1'b0;
            state_d  = ST_CSI;
          end else if (ch == tksd_pkg::CH_UP_O) begin
            emit    = 1'b0;
            state_d = ST_SS3;
          end else if ((ch >= tksd_pkg::CH_LO_A) && (ch <= tksd_pkg::CH_LO_Z)) begin
            ev = tksd_pkg::make_event(tksd_pkg::EV_CHAR, tksd_pkg::MOD_ALT,
                                      ch - tksd_pkg::CASE_OFFSET);
          end else if (ch == tksd_pkg::CH_DEL) begin
            ev = tksd_pkg::make_event(tksd_pkg::EV_KEY, tksd_pkg::MOD_ALT,
                                      tksd_pkg::KEY_BKSP);
          end else begin
            ev = tksd_pkg::make_event(tksd_pkg::EV_CHAR, tksd_pkg::MOD_ALT, ch);
          end
        end

        ST_CSI: begin
          priority if (ch == tksd_pkg::CH_UP_M) begin
            state_d = ST_MOUSE1;
          end else if (digit) begin
            first_d = digit_val;
            have1_d = 1'b1;
            state_d = ST_CSI_NUM1;
          end else if (ch == tksd_pkg::CH_SEMI) begin
            state_d = ST_CSI_SEMI;
          end else begin
            emit = 1'b1;
            ev   = csi_ev;
          end
        end

        ST_CSI_NUM1: begin
          priority if (digit) begin
            // n * 10 + digit, wrapping at the number width
            first_d = (first_q << 3) + (first_q << 1) + digit_val;
          end else if (ch == tksd_pkg::CH_SEMI) begin
            state_d = ST_CSI_SEMI;
          end else begin
            emit = 1'b1;
            ev   = csi_ev;
          end
        end

        ST_CSI_SEMI: begin
          if (digit) begin
            second_d = digit_val;
            have2_d  = 1'b1;
            state_d  = ST_CSI_NUM2;
          end else begin
            emit = 1'b1;
            ev   = csi_ev;
          end
        end

        ST_CSI_NUM2: begin
          if (digit) begin
            second_d = (second_q << 3) + (second_q << 1) + digit_val;
          end else begin
            emit = 1'b1;
            ev   = csi_ev;
          end
        end

        ST_MOUSE1: begin
          flags_d = ch;
          state_d = ST_MOUSE2;
        end

        ST_MOUSE2: begin
          col_d   = ch;
          state_d = ST_MOUSE3;
        end

        ST_MOUSE3: begin
          emit = 1'b1;
          ev   = mouse_ev;
        end

        ST_SS3: begin
          if (ch == tksd_pkg::CH_ONE) begin
            state_d = ST_SS3_ONE;
          end else begin
            emit = 1'b1;
            ev   = ss3_hit.hit ? tksd_pkg::make_event(tksd_pkg::EV_KEY,
                                                      tksd_pkg::MOD_NONE, ss3_hit.code)
                               : none_ev;
          end
        end

        ST_SS3_ONE: begin
          if (ch == tksd_pkg::CH_SEMI) begin
            state_d = ST_SS3_SEMI;
          end else begin
            emit = 1'b1;
          end
        end

        ST_SS3_SEMI: begin
          if (ch < tksd_pkg::CH_ONE) begin
            emit = 1'b1;
          end else begin
            ss3_mods_d = 3'(ch - tksd_pkg::CH_ONE);
            state_d    = ST_SS3_FINAL;
          end
        end

        ST_SS3_FINAL: begin
          emit = 1'b1;
          ev   = ss3_hit.hit ? tksd_pkg::make_event(tksd_pkg::EV_KEY, ss3_mods_q,
                                                    ss3_hit.code)
                             : none_ev;
        end

        default: begin
          emit = 1'b1;
        end
      endcase
    end

    // every event closes the sequence
    if (emit) state_d = ST_GROUND;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_GROUND;
      first_q    <= '0;
      second_q   <= '0;
      have1_q    <= 1'b0;
      have2_q    <= 1'b0;
      flags_q    <= '0;
      col_q      <= '0;
      ss3_mods_q <= '0;
    end else if (step_i) begin
      state_q    <= state_d;
      first_q    <= first_d;
      second_q   <= second_d;
      have1_q    <= have1_d;
      have2_q    <= have2_d;
      flags_q    <= flags_d;
      col_q      <= col_d;
      ss3_mods_q <= ss3_mods_d;
    end
  end

  assign ev_valid_o = step_i && emit;
  assign ev_o       = ev;

endmodule

`default_nettype wire

@@ hw/rtl/tksd_out_buf.sv @@
// Two-entry output buffer (result register plus skid entry) for decoded events.
// Depends on tksd_pkg and drives the source side of tksd_out_if.
`timescale 1ns / 1ps
`default_nettype none

module tksd_out_buf (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire tksd_pkg::out_item_t  ev_i,
  output tksd_pkg::buf_status_t     status_o,
  tksd_out_if.source                out_o
);

  logic                main_valid_q, main_valid_d;
  logic                skid_valid_q, skid_valid_d;
  tksd_pkg::out_item_t main_q, main_d;
  tksd_pkg::out_item_t skid_q, skid_d;
  logic                pop;

  assign pop = main_valid_q && out_o.ready;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // no push while the skid entry is taken
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_d       = ev_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = ev_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_o.valid         = main_valid_q;
  assign out_o.data          = main_q;
  assign status_o.main_valid = main_valid_q;
  assign status_o.skid_full  = skid_valid_q;

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the terminal key sequence decoder top level.
// Needs tksd_pkg, tksd_in_if, tksd_out_if and the decoder RTL; a local predictor
// builds the expected event, if any, of every accepted item.
`timescale 1ns / 1ps

module testbench;
  import tksd_pkg::*;

  localparam logic [2:0] BTN_RELEASE    = 3'd0;
  localparam logic [2:0] BTN_WHEEL_UP   = 3'd4;
  localparam logic [2:0] BTN_WHEEL_DOWN = 3'd5;
  localparam int         PHASE_ITEMS    = 225;
  localparam int         DRAIN_LIMIT    = 10000;

  typedef enum logic [3:0] {
    PS_GROUND, PS_ESC, PS_CSI, PS_CSI_NUM1, PS_CSI_SEMI, PS_CSI_NUM2,
    PS_MOUSE1, PS_MOUSE2, PS_MOUSE3, PS_SS3, PS_SS3_ONE, PS_SS3_SEMI, PS_SS3_FINAL
  } parse_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tksd_in_if  in_ch ();
  tksd_out_if out_ch ();

  terminal_key_sequence_decoder_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // decoder shadow state
  parse_phase_e dec_state = PS_GROUND;
  logic [15:0]  num_a = '0;
  logic [15:0]  num_b = '0;
  logic         has_a = 1'b0;
  logic         has_b = 1'b0;
  logic [7:0]   mouse_flags = '0;
  logic [7:0]   mouse_col = '0;
  logic [2:0]   ss3_mods = '0;
  out_item_t    next_ev;
  bit           next_got;

  out_item_t expected_events[$];
  in_item_t  key_sequence[$];
  int        error_count = 0;
  int        sender_idle_pct = 0;
  int        receiver_stall_pct = 0;

  logic [7:0] letter_finals[7] = '{CH_UP_A, CH_UP_B, CH_UP_C, CH_UP_D, CH_UP_F, CH_UP_H,
                                   CH_UP_Z};
  logic [7:0] ss3_finals[6] = '{CH_UP_F, CH_UP_H, CH_UP_P, CH_UP_Q, CH_UP_R, CH_UP_S};

  // ---------------------------------------------------------------------------
  // event predictor

  function automatic void produce(logic [1:0] kind, logic [2:0] mods, logic [7:0] code);
    next_ev = '0;
    next_ev.event_kind = kind;
    next_ev.mod_shift  = mods[0];
    next_ev.mod_alt    = mods[1];
    next_ev.mod_ctrl   = mods[2];
    next_ev.key_code   = code;
    next_got  = 1'b1;
    dec_state = PS_GROUND;
  endfunction

  function automatic void produce_none();
    produce(EV_NONE, MOD_NONE, 8'd0);
  endfunction

  function automatic int tilde_key(logic [15:0] n);
    case (n)
      16'd1, 16'd7: return int'(KEY_HOME);
      16'd2, 16'd8: return int'(KEY_INS);
      16'd3:        return int'(KEY_DEL);
      16'd4:        return int'(KEY_END);
      16'd5:        return int'(KEY_PGUP);
      16'd6:        return int'(KEY_PGDN);
      16'd11, 16'd12, 16'd13, 16'd14, 16'd15:
        return int'(KEY_F1) + int'(n) - 11;
      16'd17, 16'd18, 16'd19, 16'd20, 16'd21:
        return int'(KEY_F1) + 5 + int'(n) - 17;
      16'd23, 16'd24:
        return int'(KEY_F1) + 10 + int'(n) - 23;
      default: return -1;
    endcase
  endfunction

  function automatic int ss3_key(logic [7:0] ch);
    case (ch)
      CH_UP_F: return int'(KEY_END);
      CH_UP_H: return int'(KEY_HOME);
      CH_UP_P, CH_UP_Q, CH_UP_R, CH_UP_S: return int'(KEY_F1) + int'(ch - CH_UP_P);
      default: return -1;
    endcase
  endfunction

  function automatic void csi_end(logic [7:0] ch);
    logic [2:0]  mods;
    logic [15:0] less_one;
    bit          bad;
    int          code;
    mods = MOD_NONE;
    bad  = 1'b0;
    if (ch == CH_TILDE) begin
      if (!has_a || (has_b && num_b == 16'd0)) begin
        bad = 1'b1;
      end else if (has_b) begin
        less_one = num_b - 16'd1;
        mods = less_one[2:0];
      end
      code = tilde_key(num_a);
      if (bad || code < 0) produce_none();
      else produce(EV_KEY, mods, code[7:0]);
      return;
    end
    if (has_a) begin
      if (has_b) begin
        if (num_a != 16'd1 || num_b == 16'd0) bad = 1'b1;
        less_one = num_b - 16'd1;
      end else begin
        if (num_a == 16'd0) bad = 1'b1;
        less_one = num_a - 16'd1;
      end
      mods = less_one[2:0];
    end
    if (bad) begin
      produce_none();
      return;
    end
    case (ch)
      CH_UP_A: produce(EV_KEY, mods, KEY_UP);
      CH_UP_B: produce(EV_KEY, mods, KEY_DOWN);
      CH_UP_C: produce(EV_KEY, mods, KEY_RIGHT);
      CH_UP_D: produce(EV_KEY, mods, KEY_LEFT);
      CH_UP_F: produce(EV_KEY, mods, KEY_END);
      CH_UP_H: produce(EV_KEY, mods, KEY_HOME);
      CH_UP_Z: produce(EV_KEY, MOD_SHIFT, KEY_TAB);
      default: produce_none();
    endcase
  endfunction

  function automatic void csi_after_number(logic [7:0] ch);
    if (ch == CH_SEMI) dec_state = PS_CSI_SEMI;
    else csi_end(ch);
  endfunction

  // advance the shadow state by one item; next_got tells whether an event results
  function automatic void decode_item(in_item_t it);
    logic [7:0]  ch;
    logic [15:0] dval;
    logic [7:0]  mod_byte;
    logic [2:0]  btn;
    bit          digit;
    int          code;
    ch       = it.rx_byte;
    digit    = (ch >= CH_ZERO) && (ch <= CH_NINE);
    dval     = {8'd0, ch - CH_ZERO};
    next_got = 1'b0;
    next_ev  = '0;
    if (it.cmd == CMD_IDLE) begin
      case (dec_state)
        PS_GROUND: ;
        PS_ESC:    produce(EV_KEY, MOD_NONE, KEY_ESC);
        PS_CSI:    produce(EV_CHAR, MOD_ALT, CH_LBRACKET);
        PS_SS3:    produce(EV_CHAR, MOD_ALT, CH_UP_O);
        default:   produce_none();
      endcase
      return;
    end
    case (dec_state)
      PS_GROUND: begin
        if (ch == CH_TAB) produce(EV_KEY, MOD_NONE, KEY_TAB);
        else if (ch == CH_LF) produce(EV_KEY, MOD_CTRL, KEY_ENTER);
        else if (ch == CH_CR) produce(EV_KEY, MOD_NONE, KEY_ENTER);
        else if (ch >= CH_CTRL_A && ch <= CH_CTRL_Z)
          produce(EV_CHAR, MOD_CTRL, ch + CTRL_OFFSET);
        else if (ch == CH_ESC) dec_state = PS_ESC;
        else if (ch == CH_US) produce(EV_CHAR, MOD_CTRL | MOD_ALT, CH_MINUS);
        else if (ch == CH_DEL) produce(EV_KEY, MOD_NONE, KEY_BKSP);
        else if (ch == CH_NUL || ch == CH_FF) produce_none();
        else produce(EV_CHAR, MOD_NONE, ch);
      end
      PS_ESC: begin
        if (ch == CH_ESC) produce(EV_KEY, MOD_NONE, KEY_ESC);
        else if (ch == CH_LF) produce(EV_KEY, MOD_ALT, KEY_ENTER);
        else if (ch >= CH_CTRL_A && ch <= CH_CTRL_Z)
          produce(EV_CHAR, MOD_CTRL | MOD_ALT, ch + CTRL_OFFSET);
        else if (ch == CH_US) produce(EV_CHAR, MOD_CTRL | MOD_ALT | MOD_SHIFT, CH_MINUS);
        else if (ch == CH_LBRACKET) begin
          num_a = '0;
          num_b = '0;
          has_a = 1'b0;
          has_b = 1'b0;
          dec_state = PS_CSI;
        end else if (ch == CH_UP_O) dec_state = PS_SS3;
        else if (ch >= CH_LO_A && ch <= CH_LO_Z) produce(EV_CHAR, MOD_ALT, ch - CASE_OFFSET);
        else if (ch == CH_DEL) produce(EV_KEY, MOD_ALT, KEY_BKSP);
        else produce(EV_CHAR, MOD_ALT, ch);
      end
      PS_CSI: begin
        if (ch == CH_UP_M) dec_state = PS_MOUSE1;
        else if (digit) begin
          num_a = dval;
          has_a = 1'b1;
          dec_state = PS_CSI_NUM1;
        end else csi_after_number(ch);
      end
      PS_CSI_NUM1: begin
        if (digit) num_a = num_a * 16'd10 + dval;
        else csi_after_number(ch);
      end
      PS_CSI_SEMI: begin
        if (digit) begin
          num_b = dval;
          has_b = 1'b1;
          dec_state = PS_CSI_NUM2;
        end else csi_end(ch);
      end
      PS_CSI_NUM2: begin
        if (digit) num_b = num_b * 16'd10 + dval;
        else csi_end(ch);
      end
      PS_MOUSE1: begin
        mouse_flags = ch;
        dec_state = PS_MOUSE2;
      end
      PS_MOUSE2: begin
        mouse_col = ch;
        dec_state = PS_MOUSE3;
      end
      PS_MOUSE3: begin
        if (mouse_flags[6:5] == 2'b11) btn = mouse_flags[0] ? BTN_WHEEL_DOWN : BTN_WHEEL_UP;
        else if (mouse_flags[1:0] == 2'b11) btn = BTN_RELEASE;
        else btn = {1'b0, mouse_flags[1:0]} + 3'd1;
        produce(EV_MOUSE, mouse_flags[4:2], 8'd0);
        next_ev.mouse_column = mouse_col - MOUSE_BIAS;
        next_ev.mouse_row    = ch - MOUSE_BIAS;
        next_ev.mouse_button = btn;
      end
      PS_SS3: begin
        code = ss3_key(ch);
        if (ch == CH_ONE) dec_state = PS_SS3_ONE;
        else if (code < 0) produce_none();
        else produce(EV_KEY, MOD_NONE, code[7:0]);
      end
      PS_SS3_ONE: begin
        if (ch != CH_SEMI) produce_none();
        else dec_state = PS_SS3_SEMI;
      end
      PS_SS3_SEMI: begin
        mod_byte = ch - CH_ONE;
        if (ch < CH_ONE) produce_none();
        else begin
          ss3_mods = mod_byte[2:0];
          dec_state = PS_SS3_FINAL;
        end
      end
      PS_SS3_FINAL: begin
        code = ss3_key(ch);
        if (code < 0) produce_none();
        else produce(EV_KEY, ss3_mods, code[7:0]);
      end
      default: produce_none();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // input side

  task automatic send_item(logic cmd, logic [7:0] rx);
    in_item_t it;
    it.cmd = cmd;
    it.rx_byte = rx;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    decode_item(it);
    if (next_got) expected_events.push_back(next_ev);
  endtask

  task automatic send_byte(logic [7:0] rx);
    send_item(CMD_BYTE, rx);
  endtask

  task automatic send_idle();
    send_item(CMD_IDLE, 8'($urandom));
  endtask

  // hold the sender off until every predicted event has come out
  task automatic wait_for_events();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // output side

  always @(negedge clk_i) out_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready) begin
      got = out_ch.data;
      if (expected_events.size() == 0) begin
        error_count++;
        $display("%0t: event with nothing expected, expected none, actual %h", $time, got);
      end else begin
        want = expected_events.pop_front();
        check_field("event_kind", 8'(want.event_kind), 8'(got.event_kind));
        check_field("mod_shift", 8'(want.mod_shift), 8'(got.mod_shift));
        check_field("mod_alt", 8'(want.mod_alt), 8'(got.mod_alt));
        check_field("mod_ctrl", 8'(want.mod_ctrl), 8'(got.mod_ctrl));
        check_field("key_code", want.key_code, got.key_code);
        check_field("mouse_column", want.mouse_column, got.mouse_column);
        check_field("mouse_row", want.mouse_row, got.mouse_row);
        check_field("mouse_button", 8'(want.mouse_button), 8'(got.mouse_button));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed tests

  task automatic test_ground_bytes();
    send_byte(CH_NUL);
    send_byte(CH_FF);
    send_byte(CH_TAB);
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_byte(CH_CTRL_A);
    send_byte(CH_US);
    send_byte(CH_DEL);
    send_idle();
  endtask

  task automatic test_escape_endings();
    send_byte(CH_ESC);
    send_byte(CH_ESC);
    send_byte(CH_ESC);
    send_idle();
    send_byte(CH_ESC);
    send_byte(CH_LBRACKET);
    send_idle();
    send_byte(CH_ESC);
    send_byte(CH_UP_O);
    send_idle();
  endtask

  task automatic test_csi_and_mouse();
    send_byte(CH_ESC);
    send_byte(CH_LBRACKET);
    send_byte(CH_UP_Z);
    // release report at column 0, row wrapping to 255
    send_byte(CH_ESC);
    send_byte(CH_LBRACKET);
    send_byte(CH_UP_M);
    send_byte(8'h23);
    send_byte(8'h21);
    send_byte(8'h20);
  endtask

  // ---------------------------------------------------------------------------
  // random sequences

  function automatic void push_byte(logic [7:0] b);
    in_item_t it;
    it.cmd = CMD_BYTE;
    it.rx_byte = b;
    key_sequence.push_back(it);
  endfunction

  function automatic void push_idle();
    in_item_t it;
    it.cmd = CMD_IDLE;
    it.rx_byte = 8'($urandom);
    key_sequence.push_back(it);
  endfunction

  function automatic void push_number(int n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic int pick_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(1, 8);
    if (r < 70) return 0;
    if (r < 85) return $urandom_range(9, 40);
    // values past the parameter width wrap
    return 65536 * $urandom_range(1, 15) + $urandom_range(0, 30);
  endfunction

  function automatic void build_key_sequence();
    int kind;
    int form;
    int cut;
    key_sequence.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      push_byte(8'($urandom));
    end else if (kind < 22) begin
      push_byte(CH_ESC);
      push_byte(8'($urandom));
    end else if (kind < 45) begin
      push_byte(CH_ESC);
      push_byte(CH_LBRACKET);
      form = $urandom_range(0, 3);
      if (form == 1) push_number(pick_number());
      if (form == 2) push_number(($urandom_range(0, 3) != 0) ? 1 : pick_number());
      if (form >= 2) begin
        push_byte(CH_SEMI);
        push_number(pick_number());
      end
      if ($urandom_range(0, 9) != 0) push_byte(letter_finals[$urandom_range(0, 6)]);
      else push_byte(8'($urandom));
    end else if (kind < 62) begin
      push_byte(CH_ESC);
      push_byte(CH_LBRACKET);
      if ($urandom_range(0, 19) != 0)
        push_number(($urandom_range(0, 9) < 7) ? $urandom_range(0, 26) : pick_number());
      if ($urandom_range(0, 1) != 0) begin
        push_byte(CH_SEMI);
        push_number(pick_number());
      end
      if ($urandom_range(0, 9) != 0) push_byte(CH_TILDE);
      else push_byte(8'($urandom));
    end else if (kind < 77) begin
      push_byte(CH_ESC);
      push_byte(CH_UP_O);
      form = $urandom_range(0, 2);
      if (form != 0) push_byte(CH_ONE);
      if (form == 1) begin
        push_byte(CH_SEMI);
        if ($urandom_range(0, 4) != 0) push_byte(CH_ONE + 8'($urandom_range(0, 7)));
        else push_byte(8'($urandom));
      end
      if (form != 2 && $urandom_range(0, 4) != 0) push_byte(ss3_finals[$urandom_range(0, 5)]);
      else push_byte(8'($urandom));
    end else if (kind < 90) begin
      push_byte(CH_ESC);
      push_byte(CH_LBRACKET);
      push_byte(CH_UP_M);
      push_byte(8'($urandom));
      push_byte(8'($urandom));
      push_byte(8'($urandom));
    end else begin
      push_idle();
    end
    // break off some sequences early
    if (key_sequence.size() > 1 && $urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, key_sequence.size() - 1);
      while (key_sequence.size() > cut) void'(key_sequence.pop_back());
      if ($urandom_range(0, 1) != 0) push_idle();
      else push_byte(8'($urandom));
    end
    if ($urandom_range(0, 9) == 0) push_idle();
  endfunction

  task automatic test_random_traffic(int idle_pct, int stall_pct);
    int sent;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      build_key_sequence();
      foreach (key_sequence[i]) send_item(key_sequence[i].cmd, key_sequence[i].rx_byte);
      sent += key_sequence.size();
    end
    wait_for_events();
  endtask

  // ---------------------------------------------------------------------------

  initial begin
    int waited;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_ground_bytes();
    test_escape_endings();
    test_csi_and_mouse();
    wait_for_events();

    test_random_traffic(0, 0);
    test_random_traffic(73, 0);
    test_random_traffic(0, 73);
    test_random_traffic(34, 34);

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    waited = 0;
    while (expected_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_events.size() != 0) begin
      error_count += expected_events.size();
      $display("%0t: %0d expected events never arrived", $time, expected_events.size());
    end
    repeat (8) @(posedge clk_i);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
